// ----- rtl/core/quad_x_mixer_desaturation_unit_assert.svh -----
// Assertion macros for the quad-X mixer desaturation unit.
`ifndef QUAD_X_MIXER_DESATURATION_UNIT_ASSERT_SVH
`define QUAD_X_MIXER_DESATURATION_UNIT_ASSERT_SVH
`define QXM_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("qxm check failed");
`define QXM_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("qxm check failed");
`endif

// ----- rtl/core/qxm_pkg.sv -----
// Package with types and constants of the quad-X mixer.
`default_nettype none
package qxm_pkg;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int SCALE_BITS_DEF = 16;
  localparam int DW = 16;
  localparam int MW = 15;

  typedef struct packed {
    logic signed [DW-1:0] thrust_demand;
    logic signed [DW-1:0] roll_demand;
    logic signed [DW-1:0] pitch_demand;
    logic signed [DW-1:0] yaw_demand;
  } qxm_in_t;

  typedef struct packed {
    logic [MW-1:0] motor_front_right;
    logic [MW-1:0] motor_rear_left;
    logic [MW-1:0] motor_front_left;
    logic [MW-1:0] motor_rear_right;
    logic [3:0] clamp_flags;
    logic signed [DW-1:0] roll_shortfall;
    logic signed [DW-1:0] pitch_shortfall;
    logic signed [DW-1:0] yaw_shortfall;
    logic signed [DW-1:0] thrust_shortfall;
  } qxm_out_t;
endpackage
`default_nettype wire

// ----- rtl/core/qxm_div_cell.sv -----
// One restoring division cell producing one quotient bit per stage.
`default_nettype none
module qxm_div_cell #(
  parameter int RW = 20,
  parameter int SB = 16,
  parameter int PW = 40
) (
  input  wire logic          clk,
  input  wire logic          adv,
  input  wire logic [RW-1:0] rem_i,
  input  wire logic [RW-1:0] den_i,
  input  wire logic [SB:0]   quo_i,
  input  wire logic [PW-1:0] pay_i,
  output logic      [RW-1:0] rem_o,
  output logic      [RW-1:0] den_o,
  output logic      [SB:0]   quo_o,
  output logic      [PW-1:0] pay_o
);
  logic [RW:0] sh;
  logic        ge;
  logic [RW-1:0] rem_r, den_r;
  logic [SB:0]   quo_r;
  logic [PW-1:0] pay_r;

  assign sh = {rem_i, 1'b0};
  assign ge = sh >= {1'b0, den_i};

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r <= ge ? RW'(sh - {1'b0, den_i}) : sh[RW-1:0];
      den_r <= den_i;
      quo_r <= {quo_i[SB-1:0], ge};
      pay_r <= pay_i;
    end
  end

  assign rem_o = rem_r;
  assign den_o = den_r;
  assign quo_o = quo_r;
  assign pay_o = pay_r;
endmodule
`default_nettype wire

// ----- rtl/core/quad_x_mixer_desaturation_unit.sv -----
// Top level of the quad-X mixer with thrust-span desaturation.
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | qxm_in_t demand request
// out     | output    | out_valid/out_stall| qxm_out_t motor request
// One request is accepted every cycle unless an output stall holds the pipeline.
// The division chain of SCALE_BITS cells lies between the input register and the products and output registers.
// The whole pipeline advances together; an output stall while out_valid is high holds every stage.
// Reset clears only the stage valid bits.
`default_nettype none
`include "quad_x_mixer_desaturation_unit_assert.svh"
module quad_x_mixer_desaturation_unit #(
  parameter int FRACTION_BITS = qxm_pkg::FRAC_BITS_DEF,
  parameter int SCALE_BITS    = qxm_pkg::SCALE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire qxm_pkg::qxm_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output qxm_pkg::qxm_out_t     out_data
);
  import qxm_pkg::*;

  localparam int NC = SCALE_BITS;
  localparam int RW = 20;
  localparam int PW = 4 * DW + (DW + 1) + 1;
  localparam int NS = NC + 3;
  localparam int AW = 19;
  localparam int QW = SCALE_BITS + 2;

  logic adv;
  logic [NS-1:0] vld_r, vld_nxt;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_comb begin
    vld_nxt = {vld_r[NS-2:0], in_valid};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= vld_nxt;
  end
  assign out_valid = vld_r[NS-1];

  // Stage 0: thrust clamp, mix terms, peak and span.
  logic signed [DW:0] one_q;
  logic signed [DW:0] thr_c;
  logic signed [AW-1:0] mx0, mx1, mx2, mx3, r, p, y;
  logic [AW-1:0] a0, a1, a2, a3, pk, m01, m23;
  logic [DW:0] span;
  assign one_q = (DW+1)'(1) <<< FRACTION_BITS;
  assign r = AW'(in_data.roll_demand);
  assign p = AW'(in_data.pitch_demand);
  assign y = AW'(in_data.yaw_demand);
  always_comb begin
    thr_c = (DW+1)'(in_data.thrust_demand);
    if (in_data.thrust_demand < 0) thr_c = '0;
    else if ((DW+1)'(in_data.thrust_demand) > one_q) thr_c = one_q;
    mx0 = -r - p + y;
    mx1 = -r + p - y;
    mx2 = r + p + y;
    mx3 = r - p - y;
    a0 = mx0[AW-1] ? AW'(-mx0) : mx0;
    a1 = mx1[AW-1] ? AW'(-mx1) : mx1;
    a2 = mx2[AW-1] ? AW'(-mx2) : mx2;
    a3 = mx3[AW-1] ? AW'(-mx3) : mx3;
    m01 = a0 > a1 ? a0 : a1;
    m23 = a2 > a3 ? a2 : a3;
    pk = m01 > m23 ? m01 : m23;
    span = ((one_q - thr_c) < thr_c) ? (DW+1)'(one_q - thr_c) : thr_c;
  end

  logic [DW:0] span_r;
  logic [AW-1:0] pk_r;
  logic [PW-1:0] pay_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      span_r <= span;
      pk_r <= pk;
      pay_r <= {in_data.thrust_demand, in_data.roll_demand, in_data.pitch_demand,
                in_data.yaw_demand, thr_c, (pk != '0) && ({2'b0, span} < pk)};
    end
  end

  // Division chain: span * 2^SCALE_BITS / peak, one quotient bit per cell.
  // The span is below the peak whenever the quotient is used, so the
  // remainder starts at the span.
  logic [RW-1:0] rem_c [NC+1];
  logic [RW-1:0] den_c [NC+1];
  logic [SCALE_BITS:0] quo_c [NC+1];
  logic [PW-1:0] pay_c [NC+1];
  assign rem_c[0] = RW'(span_r);
  assign den_c[0] = RW'(pk_r);
  assign quo_c[0] = '0;
  assign pay_c[0] = pay_r;

  genvar g;
  generate
    for (g = 0; g < NC; g++) begin : g_cell
      qxm_div_cell #(.RW(RW), .SB(SCALE_BITS), .PW(PW)) u_cell (
        .clk(clk), .adv(adv),
        .rem_i(rem_c[g]),
        .den_i(den_c[g]), .quo_i(quo_c[g]), .pay_i(pay_c[g]),
        .rem_o(rem_c[g+1]), .den_o(den_c[g+1]), .quo_o(quo_c[g+1]),
        .pay_o(pay_c[g+1]));
    end
  endgenerate

  logic [QW-1:0] scale;
  logic [PW-1:0] pf;
  logic sat;
  assign pf = pay_c[NC];
  assign sat = pf[0];
  assign scale = sat ? QW'(quo_c[NC]) : (QW'(1) << SCALE_BITS);

  // Products stage.
  logic signed [DW-1:0] tq, rq, pq, yq;
  logic signed [DW:0] thc;
  assign {tq, rq, pq, yq, thc} = pf[PW-1:1];
  logic signed [QW:0] ss;
  assign ss = {1'b0, scale};
  logic signed [AW-1:0] fr, fp, fy;
  logic signed [AW+QW:0] prr, ppp, pyy;
  assign prr = AW'(rq) * ss;
  assign ppp = AW'(pq) * ss;
  assign pyy = AW'(yq) * ss;
  assign fr = AW'(prr >>> SCALE_BITS);
  assign fp = AW'(ppp >>> SCALE_BITS);
  assign fy = AW'(pyy >>> SCALE_BITS);

  logic signed [AW-1:0] fr_r, fp_r, fy_r;
  logic signed [DW-1:0] tq_r, rq_r, pq_r, yq_r;
  logic signed [DW:0] thc_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      fr_r <= fr; fp_r <= fp; fy_r <= fy;
      tq_r <= tq; rq_r <= rq; pq_r <= pq; yq_r <= yq; thc_r <= thc;
    end
  end

  // Output stage: each whole mix term is scaled and then floored, added to the thrust and clamped.
  logic signed [AW+QW:0] e0, e1, e2, e3;
  logic signed [AW+1:0] q0, q1, q2, q3;
  logic signed [AW+1:0] thx;
  logic signed [QW:0] ssr2;
  logic [QW-1:0] scale_r;
  always_ff @(posedge clk) begin
    if (adv) scale_r <= scale;
  end
  logic signed [AW-1:0] mm0, mm1, mm2, mm3;
  assign mm0 = -AW'(rq_r) - AW'(pq_r) + AW'(yq_r);
  assign mm1 = -AW'(rq_r) + AW'(pq_r) - AW'(yq_r);
  assign mm2 = AW'(rq_r) + AW'(pq_r) + AW'(yq_r);
  assign mm3 = AW'(rq_r) - AW'(pq_r) - AW'(yq_r);
  assign ssr2 = {1'b0, scale_r};
  assign e0 = mm0 * ssr2;
  assign e1 = mm1 * ssr2;
  assign e2 = mm2 * ssr2;
  assign e3 = mm3 * ssr2;
  assign thx = (AW+2)'(thc_r);
  assign q0 = thx + (AW+2)'(e0 >>> SCALE_BITS);
  assign q1 = thx + (AW+2)'(e1 >>> SCALE_BITS);
  assign q2 = thx + (AW+2)'(e2 >>> SCALE_BITS);
  assign q3 = thx + (AW+2)'(e3 >>> SCALE_BITS);

  function automatic logic [MW:0] clampm(input logic signed [AW+1:0] v,
                                          input logic [DW:0] one);
    logic [MW:0] res;
    if (v < 0) res = {1'b1, MW'(0)};
    else if (v > (AW+2)'(one)) res = {1'b1, MW'(one)};
    else res = {1'b0, MW'(v)};
    return res;
  endfunction

  function automatic logic [DW-1:0] sat16(input logic signed [AW+1:0] v);
    logic [DW-1:0] res;
    if (v < -(AW+2)'(32768)) res = 16'h8000;
    else if (v > (AW+2)'(32767)) res = 16'h7fff;
    else res = DW'(v);
    return res;
  endfunction

  logic [MW:0] c0, c1, c2, c3;
  qxm_out_t od;
  always_comb begin
    c0 = clampm(q0, one_q);
    c1 = clampm(q1, one_q);
    c2 = clampm(q2, one_q);
    c3 = clampm(q3, one_q);
    od.motor_front_right = c0[MW-1:0];
    od.motor_rear_left = c1[MW-1:0];
    od.motor_front_left = c2[MW-1:0];
    od.motor_rear_right = c3[MW-1:0];
    od.clamp_flags = {c3[MW], c2[MW], c1[MW], c0[MW]};
    od.roll_shortfall = sat16((AW+2)'(rq_r) - (AW+2)'(fr_r));
    od.pitch_shortfall = sat16((AW+2)'(pq_r) - (AW+2)'(fp_r));
    od.yaw_shortfall = sat16((AW+2)'(yq_r) - (AW+2)'(fy_r));
    od.thrust_shortfall = sat16((AW+2)'(tq_r) - (AW+2)'(thc_r));
  end

  qxm_out_t out_r;
  always_ff @(posedge clk) begin
    if (adv) out_r <= od;
  end
  assign out_data = out_r;

  logic unused;
  assign unused = ^{rem_c[NC], den_c[NC]};

  `QXM_ASSERT_IMPL(a_stall_only_when_full, in_stall, out_valid && out_stall)
  `QXM_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid)
  `QXM_ASSERT_IMPL(a_flag_range, out_valid && !out_data.clamp_flags[0],
                   out_data.motor_front_right <= MW'(one_q))
endmodule
`default_nettype wire

// ----- tb/sv/quad_x_mixer_desaturation_unit_test.sv -----
// Self-checking test of the quad-X mixer with desaturation, random and directed requests.
`timescale 1ns / 1ps
module quad_x_mixer_desaturation_unit_test;
  import qxm_pkg::*;

  localparam int FRAC = 14;
  localparam int SBITS = 16;
  localparam longint ONE_Q = 64'sd1 << FRAC;
  localparam longint ONE_S = 64'sd1 << SBITS;
  localparam int LATENCY = SBITS + 3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  localparam int MODE_FREE = 0;
  localparam int MODE_SEND_IDLE = 1;
  localparam int MODE_RECV_STALL = 2;
  localparam int MODE_BOTH = 3;

  logic clk;
  logic rst_n;
  logic in_valid = 1'b0;
  logic in_stall;
  qxm_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  qxm_out_t out_data;

  qxm_in_t pending_demands[$];
  qxm_out_t expected_motors[$];
  int idle_mode = MODE_FREE;
  bit hold_req = 1'b0;
  int hold_count = 0;
  bit hold_done = 1'b0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  logic in_stall_q = 1'b0;

  quad_x_mixer_desaturation_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic longint floor_scaled(longint p);
    return p >>> SBITS;
  endfunction

  function automatic longint sat16(longint v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic qxm_out_t mix_demand(qxm_in_t d);
    qxm_out_t r;
    longint t_req, roll, pitch, yaw, thrust, peak, span, scale, req, c, a;
    longint mix[4];
    t_req = longint'(d.thrust_demand);
    roll = longint'(d.roll_demand);
    pitch = longint'(d.pitch_demand);
    yaw = longint'(d.yaw_demand);
    thrust = t_req < 0 ? 0 : (t_req > ONE_Q ? ONE_Q : t_req);
    mix[0] = -roll - pitch + yaw;
    mix[1] = -roll + pitch - yaw;
    mix[2] = roll + pitch + yaw;
    mix[3] = roll - pitch - yaw;
    peak = 0;
    for (int i = 0; i < 4; i++) begin
      a = mix[i] < 0 ? -mix[i] : mix[i];
      if (a > peak) peak = a;
    end
    span = (ONE_Q - thrust) < thrust ? (ONE_Q - thrust) : thrust;
    scale = ONE_S;
    if (peak > 0 && span < peak) scale = (span << SBITS) / peak;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      req = thrust + floor_scaled(mix[i] * scale);
      c = req < 0 ? 0 : (req > ONE_Q ? ONE_Q : req);
      if (c != req) r.clamp_flags[i] = 1'b1;
      case (i)
        0: r.motor_front_right = MW'(c);
        1: r.motor_rear_left = MW'(c);
        2: r.motor_front_left = MW'(c);
        default: r.motor_rear_right = MW'(c);
      endcase
    end
    r.roll_shortfall = DW'(sat16(roll - floor_scaled(roll * scale)));
    r.pitch_shortfall = DW'(sat16(pitch - floor_scaled(pitch * scale)));
    r.yaw_shortfall = DW'(sat16(yaw - floor_scaled(yaw * scale)));
    r.thrust_shortfall = DW'(sat16(t_req - thrust));
    return r;
  endfunction

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 2000));
      2: return -16'($urandom_range(0, 2000));
      3: return 16'($urandom_range(0, 8192));
      4: return -16'($urandom_range(0, 8192));
      default: return 16'($urandom_range(0, 20000) - 10000);
    endcase
  endfunction

  function automatic qxm_in_t random_demand();
    qxm_in_t d;
    case ($urandom_range(0, 7))
      0: d.thrust_demand = 16'($urandom);
      1: d.thrust_demand = 16'($urandom_range(0, 1)) * 16'(ONE_Q);
      default: d.thrust_demand = 16'($urandom_range(0, 16384));
    endcase
    d.roll_demand = pick_axis();
    d.pitch_demand = pick_axis();
    d.yaw_demand = pick_axis();
    return d;
  endfunction

  task automatic queue_demand(logic [15:0] t, logic [15:0] r, logic [15:0] p,
                              logic [15:0] y);
    qxm_in_t d;
    d.thrust_demand = t;
    d.roll_demand = r;
    d.pitch_demand = p;
    d.yaw_demand = y;
    pending_demands.push_back(d);
  endtask

  task automatic drain_all();
    while (pending_demands.size() != 0 || expected_motors.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  always @(posedge clk) in_stall_q <= in_valid && in_stall;

  // The driver offers the head of the queue and holds it while it is stalled.
  always @(negedge clk) begin
    bit skip;
    skip = (idle_mode == MODE_SEND_IDLE || idle_mode == MODE_BOTH)
           && ($urandom_range(0, 99) < ((idle_mode == MODE_BOTH) ? 30 : 83));
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall_q)) begin
      if (pending_demands.size() != 0 && !skip) begin
        in_data <= pending_demands.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
    end else if (idle_mode == MODE_RECV_STALL) begin
      out_stall <= ($urandom_range(0, 99) < 83);
    end else if (idle_mode == MODE_BOTH) begin
      out_stall <= ($urandom_range(0, 99) < 30);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // The monitor predicts on input acceptance and checks on output acceptance.
  always @(posedge clk) begin
    qxm_out_t want;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        expected_motors.push_back(mix_demand(in_data));
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_motors.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected request %h", out_data);
        end else begin
          want = expected_motors.pop_front();
          if (want !== out_data) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("mismatch: expected %p actual %p", want, out_data);
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("quad_x_mixer_desaturation_unit_test: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero peak, zero span, full scale, clamped thrust, field extremes.
    queue_demand(16'd8192, 16'd0, 16'd0, 16'd0);
    queue_demand(16'd0, 16'd1000, 16'd0, 16'd0);
    queue_demand(16'd16384, 16'd0, 16'd1000, 16'd0);
    queue_demand(16'd8192, 16'd100, -16'd200, 16'd300);
    queue_demand(16'd8192, 16'd8000, 16'd8000, 16'd8000);
    queue_demand(-16'd1, 16'd50, 16'd50, 16'd50);
    queue_demand(16'h8000, 16'd0, 16'd0, 16'd0);
    queue_demand(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    queue_demand(16'd4000, 16'h8000, 16'h8000, 16'h8000);
    queue_demand(16'd4000, 16'h7FFF, 16'h8000, 16'h7FFF);
    queue_demand(16'd12000, -16'd1, -16'd1, -16'd1);
    queue_demand(16'd1, 16'd3, -16'd5, 16'd7);
    queue_demand(16'd16383, -16'd3, 16'd5, -16'd7);
    queue_demand(16'd8192, 16'hFFFF, 16'h5555, 16'hAAAA);
    queue_demand(16'd16385, 16'd0, 16'd0, 16'd1);
    drain_all();

    for (int phase = 0; phase < 4; phase++) begin
      idle_mode = phase;
      for (int k = 0; k < 440; k++) pending_demands.push_back(random_demand());
      if (phase == MODE_FREE) hold_req = 1'b1;
      drain_all();
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0 && expected_motors.size() == 0) begin
      $display("quad_x_mixer_desaturation_unit_test: clean");
    end else begin
      $display("quad_x_mixer_desaturation_unit_test: errors");
    end
    $finish;
  end
endmodule
